FILE: hdl/utf8_to_display_glyph_filter_macros.svh
// assertion macros for the utf8 display glyph filter
`ifndef UTF8_TO_DISPLAY_GLYPH_FILTER_MACROS_SVH
`define UTF8_TO_DISPLAY_GLYPH_FILTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define U2G_ASSERT_IMPLY(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// next-cycle implication, checked outside reset
`define U2G_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

FILE: hdl/u2g_pkg.sv
// types, constants and lookup functions shared by the glyph filter modules
package u2g_pkg;

  localparam int MAX_GLYPHS = 64;
  localparam int GCNT_W     = $clog2(MAX_GLYPHS + 1);
  localparam logic [5:0] SPACE_SAT = 6'd63;

  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_QMARK = 7'h3F;
  localparam logic [7:0] B_CR     = 8'h0D;
  localparam logic [7:0] B_LF     = 8'h0A;

  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;
  localparam logic [7:0] LEAD_ED  = 8'hED;
  localparam logic [7:0] LEAD_C3  = 8'hC3;
  localparam logic [7:0] LIM_A0   = 8'hA0;
  localparam logic [7:0] LIM_90   = 8'h90;

  typedef struct packed {
    logic [6:0] glyph;
    logic [5:0] spaces;
    logic       has_glyph;
    logic       eot;
  } result_t;

  typedef struct packed {
    logic [7:0]        lead;
    logic [7:0]        second;
    logic [1:0]        hc;
    logic [GCNT_W-1:0] gcnt;
    logic [5:0]        pend;
    logic              seen;
  } state_t;

  typedef struct packed {
    logic [2:0]        n;
    result_t [3:0]     res;
  } step_out_t;

  // sequence length implied by a lead byte, 1 when not a valid lead
  function automatic logic [2:0] seq_len(input logic [7:0] lead);
    logic [2:0] len;
    len = 3'd1;
    if (lead >= LEAD2_LO && lead <= LEAD2_HI) len = 3'd2;
    else if (lead >= LEAD3_LO && lead <= LEAD3_HI) len = 3'd3;
    else if (lead >= LEAD4_LO && lead <= LEAD4_HI) len = 3'd4;
    return len;
  endfunction

  // accented spanish letters after a C3 lead
  function automatic logic [6:0] c3_letter(input logic [7:0] second);
    logic [6:0] g;
    case (second)
      8'h81, 8'hA1:               g = 7'h41;
      8'h89, 8'hA9:               g = 7'h45;
      8'h8D, 8'hAD:               g = 7'h49;
      8'h93, 8'hB3:               g = 7'h4F;
      8'h9A, 8'h9C, 8'hBA, 8'hBC: g = 7'h55;
      8'h91, 8'hB1:               g = 7'h4E;
      default:                    g = CH_QMARK;
    endcase
    return g;
  endfunction

  // single ascii byte to display glyph
  function automatic logic [6:0] map_ascii(input logic [7:0] b);
    logic [6:0] g;
    if (b == B_CR || b == B_LF) g = CH_SPACE;
    else if (b >= 8'h61 && b <= 8'h7A) g = b[6:0] - 7'h20;
    else if (b >= 8'h20 && b <= 8'h7E) g = b[6:0];
    else g = CH_QMARK;
    return g;
  endfunction

endpackage

FILE: hdl/u2g_step.sv
// per-byte decode, glyph cap and space trimming for one accepted beat
module u2g_step import u2g_pkg::*; (
  input  state_t     st,
  input  logic [7:0] text_byte,
  input  logic       final_byte,
  output state_t     st_next,
  output step_out_t  step
);

  logic       cont;
  logic       oor;
  logic [2:0] len_lead;
  logic [1:0] nq_pre;
  logic [1:0] nq_post;
  logic       has_c;
  logic [6:0] c;
  logic [1:0] hc_mid;
  logic [7:0] lead_mid;
  logic [7:0] second_mid;
  logic       do_fresh;
  logic [2:0] total;
  logic [6:0] ch;
  logic [GCNT_W-1:0] gcnt;
  logic [5:0] pend;
  logic       seen;
  logic [2:0] n;
  result_t [3:0] res;

  always_comb begin
    cont     = (text_byte[7:6] == 2'b10);
    len_lead = seq_len(st.lead);
    oor = (st.lead == LEAD3_LO && text_byte < LIM_A0) ||
          (st.lead == LEAD_ED  && text_byte >= LIM_A0) ||
          (st.lead == LEAD4_LO && text_byte < LIM_90) ||
          (st.lead == LEAD4_HI && text_byte >= LIM_90);

    nq_pre     = 2'd0;
    has_c      = 1'b0;
    c          = CH_QMARK;
    hc_mid     = st.hc;
    lead_mid   = st.lead;
    second_mid = st.second;
    do_fresh   = 1'b0;

    if (st.hc == 2'd0) begin
      do_fresh = 1'b1;
    end else if (!cont || (st.hc == 2'd1 && oor)) begin
      // broken sequence: one '?' per gathered byte, then retry this byte
      nq_pre   = st.hc;
      hc_mid   = 2'd0;
      do_fresh = 1'b1;
    end else begin
      if (st.hc == 2'd1) second_mid = text_byte;
      if (({1'b0, st.hc} + 3'd1) >= len_lead) begin
        hc_mid = 2'd0;
        has_c  = 1'b1;
        if (len_lead == 3'd2 && st.lead == LEAD_C3) c = c3_letter(second_mid);
        else c = CH_QMARK;
      end else begin
        hc_mid = st.hc + 2'd1;
      end
    end

    if (do_fresh) begin
      if (!text_byte[7]) begin
        has_c = 1'b1;
        c     = map_ascii(text_byte);
      end else if (seq_len(text_byte) == 3'd1) begin
        has_c = 1'b1;
        c     = CH_QMARK;
      end else begin
        lead_mid = text_byte;
        hc_mid   = 2'd1;
      end
    end

    // sequence cut by the end of text
    nq_post = final_byte ? hc_mid : 2'd0;
    total   = {1'b0, nq_pre} + {2'b00, has_c} + {1'b0, nq_post};

    gcnt = st.gcnt;
    pend = st.pend;
    seen = st.seen;
    n    = 3'd0;
    res  = '0;
    ch   = CH_QMARK;
    for (int i = 0; i < 4; i++) begin
      ch = (has_c && 2'(i) == nq_pre) ? c : CH_QMARK;
      if (3'(i) < total && gcnt < GCNT_W'(MAX_GLYPHS)) begin
        gcnt = gcnt + GCNT_W'(1);
        if (ch == CH_SPACE) begin
          if (seen && pend < SPACE_SAT) pend = pend + 6'd1;
        end else begin
          res[n[1:0]].glyph     = ch;
          res[n[1:0]].spaces    = pend;
          res[n[1:0]].has_glyph = 1'b1;
          res[n[1:0]].eot       = 1'b0;
          n    = n + 3'd1;
          pend = 6'd0;
          seen = 1'b1;
        end
      end
    end

    st_next.lead   = lead_mid;
    st_next.second = second_mid;
    st_next.hc     = hc_mid;
    st_next.gcnt   = gcnt;
    st_next.pend   = pend;
    st_next.seen   = seen;

    if (final_byte) begin
      if (n != 3'd0) begin
        res[n[1:0] - 2'd1].eot = 1'b1;
      end else begin
        // bare end marker
        res[0] = '{glyph: 7'd0, spaces: 6'd0, has_glyph: 1'b0, eot: 1'b1};
        n      = 3'd1;
      end
      st_next = '0;
    end

    step.n   = n;
    step.res = res;
  end

endmodule

FILE: hdl/utf8_to_display_glyph_filter.sv
// utf8 text to uppercase display glyph filter, top level
// path: an input beat is registered in the result group register, then in the output register
// throughput: one byte per cycle while each byte makes at most one result and the output is not
//   stalled; a byte that makes more results holds the input until the result group register,
//   draining one beat per cycle into the output register while not stalled, moves its last beat
// reset: synchronous active-high rst clears decoder state and both buffers
`include "utf8_to_display_glyph_filter_macros.svh"
module utf8_to_display_glyph_filter import u2g_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [6:0] glyph, [12:7] spaces_before, rest zero
  output logic        m_axis_tuser,   // has_glyph
  output logic        m_axis_tlast    // end_of_text
);

  state_t        st;
  state_t        st_next;
  step_out_t     step;
  result_t [3:0] grp;
  logic [2:0]    grp_cnt;
  logic          out_valid;
  result_t       out_data;
  logic          in_acc;
  logic          out_take;
  logic          load_out;

  u2g_step u_step (
    .st         (st),
    .text_byte  (s_axis_tdata),
    .final_byte (s_axis_tlast),
    .st_next    (st_next),
    .step       (step)
  );

  assign out_take      = out_valid && m_axis_tready;
  assign load_out      = (grp_cnt != 3'd0) && (!out_valid || out_take);
  // a new group may land once the previous one has fully drained
  assign s_axis_tready = (grp_cnt == 3'd0) || (grp_cnt == 3'd1 && load_out);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      grp_cnt   <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        st      <= st_next;
        grp     <= step.res;
        grp_cnt <= step.n;
      end else if (load_out) begin
        grp     <= {grp[3], grp[3:1]};
        grp_cnt <= grp_cnt - 3'd1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
        out_data  <= grp[0];
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_data.spaces, out_data.glyph};
  assign m_axis_tuser  = out_data.has_glyph;
  assign m_axis_tlast  = out_data.eot;

  `U2G_ASSERT_IMPLY(a_grp_bound, clk, rst, 1'b1, grp_cnt <= 3'd4, "result group overflow")
  `U2G_ASSERT_NEXT(a_final_clears, clk, rst, in_acc && s_axis_tlast, st == '0, "state not cleared after final byte")
  `U2G_ASSERT_IMPLY(a_bare_marker, clk, rst, m_axis_tvalid && !m_axis_tuser, m_axis_tlast && m_axis_tdata == 16'd0, "bare marker malformed")
  `U2G_ASSERT_IMPLY(a_no_space_glyph, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tdata[6:0] != CH_SPACE, "space sent as glyph")

endmodule

FILE: test/testbench.sv
// self-checking testbench for the utf8 to display glyph filter
`timescale 1ns / 1ps

import u2g_pkg::*;

class glyph_scoreboard;
  logic [7:0] lead_byte;
  logic [7:0] second_byte;
  int         gathered;
  int         glyph_total;
  logic [5:0] held_spaces;
  bit         shown_any;
  result_t    expected_q[$];
  result_t    made[$];
  int         errors;

  function new();
    wipe();
    errors = 0;
  endfunction

  function void wipe();
    lead_byte   = 8'h00;
    second_byte = 8'h00;
    gathered    = 0;
    glyph_total = 0;
    held_spaces = 6'd0;
    shown_any   = 1'b0;
  endfunction

  function int seq_bytes(logic [7:0] lead);
    if (lead >= 8'hC2 && lead <= 8'hDF) return 2;
    if (lead >= 8'hE0 && lead <= 8'hEF) return 3;
    if (lead >= 8'hF0 && lead <= 8'hF4) return 4;
    return 1;
  endfunction

  // base capital of an accented letter after a C3 lead
  function logic [6:0] accent_base(logic [7:0] s);
    case (s)
      8'h81, 8'hA1:               return 7'h41;
      8'h89, 8'hA9:               return 7'h45;
      8'h8D, 8'hAD:               return 7'h49;
      8'h93, 8'hB3:               return 7'h4F;
      8'h9A, 8'h9C, 8'hBA, 8'hBC: return 7'h55;
      8'h91, 8'hB1:               return 7'h4E;
      default:                    return CH_QMARK;
    endcase
  endfunction

  // overlong, surrogate and past-limit forms show up in the second byte
  function bit bad_second(logic [7:0] lead, logic [7:0] b);
    return (lead == 8'hE0 && b < 8'hA0) || (lead == 8'hED && b >= 8'hA0) ||
           (lead == 8'hF0 && b < 8'h90) || (lead == 8'hF4 && b >= 8'h90);
  endfunction

  function void emit(logic [6:0] c);
    result_t r;
    if (glyph_total >= MAX_GLYPHS) return;
    glyph_total++;
    if (c == CH_SPACE) begin
      if (shown_any && held_spaces != SPACE_SAT) held_spaces++;
      return;
    end
    if (made.size() >= 4) return;
    r.glyph     = c;
    r.spaces    = held_spaces;
    r.has_glyph = 1'b1;
    r.eot       = 1'b0;
    made = {made, r};
    held_spaces = 6'd0;
    shown_any   = 1'b1;
  endfunction

  function void take_fresh(logic [7:0] b);
    if (b < 8'h80) begin
      if (b == 8'h0D || b == 8'h0A) emit(CH_SPACE);
      else if (b >= 8'h61 && b <= 8'h7A) emit(b[6:0] - 7'h20);
      else if (b >= 8'h20 && b <= 8'h7E) emit(b[6:0]);
      else emit(CH_QMARK);
    end else if (seq_bytes(b) == 1) begin
      emit(CH_QMARK);
    end else begin
      lead_byte = b;
      gathered  = 1;
    end
  endfunction

  function void flush_gathered();
    repeat (gathered) emit(CH_QMARK);
    gathered = 0;
  endfunction

  // works out the beats caused by one accepted byte
  function void note_byte(logic [7:0] b, logic last);
    result_t  r;
    logic [6:0] g;
    made.delete();
    if (gathered == 0) begin
      take_fresh(b);
    end else if (b[7:6] != 2'b10 || (gathered == 1 && bad_second(lead_byte, b))) begin
      flush_gathered();
      take_fresh(b);
    end else begin
      if (gathered == 1) second_byte = b;
      gathered++;
      if (gathered >= seq_bytes(lead_byte)) begin
        g = CH_QMARK;
        if (lead_byte == 8'hC3) g = accent_base(second_byte);
        gathered = 0;
        emit(g);
      end
    end
    if (last) begin
      flush_gathered();
      if (made.size() > 0) begin
        made[made.size()-1].eot = 1'b1;
      end else begin
        r = '0;
        r.eot = 1'b1;
        made = {made, r};
      end
      wipe();
    end
    foreach (made[i]) expected_q = {expected_q, made[i]};
  endfunction

  function void check_beat(result_t got, logic [2:0] pad);
    result_t want;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected beat, expected none, got glyph %h spaces %0d has %b eot %b",
               $time, got.glyph, got.spaces, got.has_glyph, got.eot);
      return;
    end
    want = expected_q.pop_front();
    if (got.glyph !== want.glyph) begin
      errors++;
      $display("%0t: glyph mismatch, expected %h, actual %h", $time, want.glyph, got.glyph);
    end
    if (got.spaces !== want.spaces) begin
      errors++;
      $display("%0t: spaces_before mismatch, expected %0d, actual %0d",
               $time, want.spaces, got.spaces);
    end
    if (got.has_glyph !== want.has_glyph) begin
      errors++;
      $display("%0t: has_glyph mismatch, expected %b, actual %b",
               $time, want.has_glyph, got.has_glyph);
    end
    if (got.eot !== want.eot) begin
      errors++;
      $display("%0t: end_of_text mismatch, expected %b, actual %b", $time, want.eot, got.eot);
    end
    if (pad !== 3'b000) begin
      errors++;
      $display("%0t: tdata padding mismatch, expected 0, actual %b", $time, pad);
    end
  endfunction

  function int outstanding();
    return expected_q.size();
  endfunction
endclass

module testbench;
  localparam int STALL_PCT  = 38;
  localparam int DOG_LIMIT  = 2000;
  localparam int RAND_ITEMS = 350;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  glyph_scoreboard sb = new();
  logic [7:0] text_q[$];
  int  bytes_sent = 0;
  int  text_idx;
  int  dog = 0;
  bit  calm = 1'b0;

  utf8_to_display_glyph_filter dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side: check each beat and stall at random
  always @(posedge clk) begin
    result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.glyph     = m_axis_tdata[6:0];
      got.spaces    = m_axis_tdata[12:7];
      got.has_glyph = m_axis_tuser;
      got.eot       = m_axis_tlast;
      sb.check_beat(got, m_axis_tdata[15:13]);
    end
    m_axis_tready <= calm || ($urandom_range(99) >= STALL_PCT);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      dog <= 0;
    end else if (dog >= DOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      dog <= dog + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    calm = (bytes_sent >= 150 && bytes_sent < 230);
    while (!calm && $urandom_range(99) < STALL_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic drain();
    while (sb.outstanding() != 0) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic void queue_byte(logic [7:0] b);
    text_q = {text_q, b};
  endfunction

  // lead plus keep continuation bytes, second byte kept in the legal range
  function automatic void push_seq(logic [7:0] lead, int keep);
    queue_byte(lead);
    for (int k = 1; k <= keep; k++) begin
      if (k == 1 && lead == 8'hE0) queue_byte(8'($urandom_range(8'hA0, 8'hBF)));
      else if (k == 1 && lead == 8'hED) queue_byte(8'($urandom_range(8'h80, 8'h9F)));
      else if (k == 1 && lead == 8'hF0) queue_byte(8'($urandom_range(8'h90, 8'hBF)));
      else if (k == 1 && lead == 8'hF4) queue_byte(8'($urandom_range(8'h80, 8'h8F)));
      else queue_byte(8'($urandom_range(8'h80, 8'hBF)));
    end
  endfunction

  function automatic logic [7:0] any_lead(int len);
    if (len == 2) return 8'($urandom_range(8'hC2, 8'hDF));
    if (len == 3) return 8'($urandom_range(8'hE0, 8'hEF));
    return 8'($urandom_range(8'hF0, 8'hF4));
  endfunction

  function automatic void add_unit(bit plain);
    logic [7:0] accents[14] = '{8'h81, 8'hA1, 8'h89, 8'hA9, 8'h8D, 8'hAD, 8'h93,
                                8'hB3, 8'h9A, 8'h9C, 8'hBA, 8'hBC, 8'h91, 8'hB1};
    logic [7:0] edges[4] = '{8'hE0, 8'hED, 8'hF0, 8'hF4};
    logic [7:0] lead;
    int pick;
    int len;
    int keep;
    pick = plain ? $urandom_range(0, 39) : $urandom_range(0, 99);
    if (pick < 30) begin
      queue_byte(8'($urandom_range(8'h20, 8'h7E)));
    end else if (pick < 40) begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 3))
          0:       queue_byte(8'h0D);
          1:       queue_byte(8'h0A);
          default: queue_byte(8'h20);
        endcase
      end
    end else if (pick < 45) begin
      queue_byte($urandom_range(3) == 0 ? 8'h7F : 8'($urandom_range(0, 8'h1F)));
    end else if (pick < 60) begin
      queue_byte(8'hC3);
      queue_byte($urandom_range(2) != 0 ? accents[$urandom_range(0, 13)]
                                        : 8'($urandom_range(8'h80, 8'hBF)));
    end else if (pick < 68) begin
      push_seq(any_lead(2), 1);
    end else if (pick < 76) begin
      push_seq(any_lead(3), 2);
    end else if (pick < 82) begin
      push_seq(any_lead(4), 3);
    end else if (pick < 90) begin
      if ($urandom_range(1)) begin
        // second byte outside the range allowed for this lead
        lead = edges[$urandom_range(0, 3)];
        queue_byte(lead);
        if (lead == 8'hE0) queue_byte(8'($urandom_range(8'h80, 8'h9F)));
        else if (lead == 8'hF0) queue_byte(8'($urandom_range(8'h80, 8'h8F)));
        else if (lead == 8'hED) queue_byte(8'($urandom_range(8'hA0, 8'hBF)));
        else queue_byte(8'($urandom_range(8'h90, 8'hBF)));
      end else begin
        len  = $urandom_range(2, 4);
        keep = $urandom_range(0, len - 2);
        push_seq(any_lead(len), keep);
        queue_byte($urandom_range(1) ? 8'($urandom_range(0, 8'h7F))
                                     : 8'($urandom_range(8'hC0, 8'hFF)));
      end
    end else if (pick < 95) begin
      case ($urandom_range(0, 2))
        0:       queue_byte(8'($urandom_range(8'hC0, 8'hC1)));
        1:       queue_byte(8'($urandom_range(8'hF5, 8'hFF)));
        default: queue_byte(8'($urandom_range(8'h80, 8'hBF)));
      endcase
    end else begin
      queue_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  initial begin
    int units;
    int len;
    bit plain;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // controls, case folding, cr/lf and leading/trailing spaces
    text_q = '{8'h20, 8'h61, 8'h0D, 8'h0A, 8'h7A, 8'h7E, 8'h00, 8'h7F, 8'h20};
    send_text();
    // accents, broken surrogate and past-limit forms, bad leads, cut sequence
    text_q = '{8'hC3, 8'hA1, 8'hED, 8'hA0, 8'hF4, 8'h90, 8'hFF, 8'hC0, 8'hE2, 8'h82};
    send_text();
    // only a space: bare end marker
    text_q = '{8'h20};
    send_text();
    // valid four-byte sequence
    text_q = '{8'hF0, 8'h9F, 8'h98, 8'h80};
    send_text();
    drain();

    text_idx = 0;
    while (bytes_sent < RAND_ITEMS) begin
      text_q.delete();
      // a few long texts run into the glyph cap
      plain = (text_idx % 15 == 7);
      units = plain ? $urandom_range(66, 80) : $urandom_range(1, 12);
      repeat (units) add_unit(plain);
      if (!plain && $urandom_range(4) == 0) begin
        len = $urandom_range(2, 4);
        push_seq(any_lead(len), $urandom_range(0, len - 2));
      end
      if (text_idx % 7 == 3) drain();
      send_text();
      text_idx++;
    end
    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (sb.outstanding() != 0)
        $display("%0t: %0d expected beats never arrived", $time, sb.outstanding());
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
